@@ rtl/core/hdda_pkg.sv @@
// Shared types and constants for the hairline DDA rasterizer.
package hdda_pkg;

    localparam int COORD_W     = 12;             // 6.6 endpoint width inside a tile
    localparam int FRAC_BITS   = 6;
    localparam int TILE_PIXELS = 64;
    localparam int PIX_W       = 6;              // output pixel coordinate
    localparam int MAJ_PIX_W   = 7;              // rounded major pixel, 0 .. 64
    localparam int SLOPE_SHIFT = 16;
    localparam int NUM_W       = COORD_W + SLOPE_SHIFT;   // dividend width
    localparam int QUO_W       = SLOPE_SHIFT + 1;         // |slope| <= 1.0 in 1.16
    localparam int SLOPE_W     = QUO_W + 1;
    localparam int PROD_W      = SLOPE_W + FRAC_BITS + 1;
    localparam int BASE_W      = COORD_W + 2;
    localparam int ACC_W       = 26;
    localparam int DIV_STEPS   = NUM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [COORD_W-1:0]   HALF_PIXEL = COORD_W'(32);
    localparam logic [MAJ_PIX_W-1:0] TILE_MAX   = MAJ_PIX_W'(TILE_PIXELS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_INIT,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;       // capture the segment endpoints
        logic setup;      // order endpoints, round, take deltas
        logic div_start;  // launch the slope division
        logic mul;        // form slope and the first-center correction
        logic init;       // seed accumulator and major counter
        logic step;       // emit one pixel and advance
    } t_dp_cmd;

    typedef struct packed {
        logic zero_len;
        logic div_done;
        logic last_pixel;
    } t_dp_status;

endpackage

@@ rtl/core/hdda_divider.sv @@
// Restoring serial divider, one quotient bit per cycle.
module hdda_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hdda_pkg::NUM_W-1:0]    i_dividend,
    input  logic [hdda_pkg::COORD_W-1:0]  i_divisor,
    output logic [hdda_pkg::QUO_W-1:0]    o_quotient,
    output logic                          o_done
);
    import hdda_pkg::*;

    logic [NUM_W-1:0]     r_num;
    logic [COORD_W-1:0]   r_rem;
    logic [COORD_W-1:0]   r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_run;
    logic                 r_done;

    logic [COORD_W:0]     trial;
    logic                 ge;
    logic [COORD_W-1:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? COORD_W'(trial - {1'b0, r_div}) : trial[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in behind the dividend
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_num <= {r_num[NUM_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_num[QUO_W-1:0];
    assign o_done     = r_done;

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_run && !r_done)
        else $error("divider did not start");

endmodule

@@ rtl/core/hdda_datapath.sv @@
// Datapath: endpoint setup, slope division, DDA accumulator and pixel outputs.
module hdda_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hdda_pkg::t_dp_cmd             i_cmd,
    output hdda_pkg::t_dp_status          o_status,
    input  logic [hdda_pkg::COORD_W-1:0]  i_x_start,
    input  logic [hdda_pkg::COORD_W-1:0]  i_y_start,
    input  logic [hdda_pkg::COORD_W-1:0]  i_x_end,
    input  logic [hdda_pkg::COORD_W-1:0]  i_y_end,
    output logic                          o_valid,
    output logic [hdda_pkg::PIX_W-1:0]    o_pixel_x,
    output logic [hdda_pkg::PIX_W-1:0]    o_pixel_y,
    output logic                          o_last
);
    import hdda_pkg::*;

    // captured transaction
    logic [COORD_W-1:0] r_x0, r_y0, r_x1, r_y1;

    // setup results
    logic                 r_horiz;
    logic [MAJ_PIX_W-1:0] r_p0, r_p1;
    logic [FRAC_BITS-1:0] r_frac;
    logic [COORD_W-1:0]   r_min0;
    logic [COORD_W-1:0]   r_dmaj;
    logic [COORD_W-1:0]   r_dmin_mag;
    logic                 r_dmin_neg;

    // DDA state
    logic signed [SLOPE_W-1:0] r_slope;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic [MAJ_PIX_W-1:0]      r_p;

    logic                 r_valid;
    logic [PIX_W-1:0]     r_px, r_py;
    logic                 r_last;

    // setup logic
    logic [COORD_W:0]     dx, dy;
    logic [COORD_W-1:0]   adx, ady;
    logic                 horiz;
    logic [COORD_W-1:0]   a_maj0, a_maj1, a_min0, a_min1;
    logic [COORD_W-1:0]   maj0, maj1, min0, min1;
    logic [COORD_W:0]     dmin;
    logic [COORD_W:0]     rnd0, rnd1;

    logic [QUO_W-1:0] o_quo_w;
    logic             div_done;

    always_comb begin
        dx    = {1'b0, r_x1} - {1'b0, r_x0};
        dy    = {1'b0, r_y1} - {1'b0, r_y0};
        adx   = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady   = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        horiz = (adx > ady);
        a_maj0 = horiz ? r_x0 : r_y0;
        a_maj1 = horiz ? r_x1 : r_y1;
        a_min0 = horiz ? r_y0 : r_x0;
        a_min1 = horiz ? r_y1 : r_x1;
        if (a_maj0 > a_maj1) begin
            maj0 = a_maj1;
            maj1 = a_maj0;
            min0 = a_min1;
            min1 = a_min0;
        end else begin
            maj0 = a_maj0;
            maj1 = a_maj1;
            min0 = a_min0;
            min1 = a_min1;
        end
        dmin = {1'b0, min1} - {1'b0, min0};
        rnd0 = {1'b0, maj0} + {1'b0, HALF_PIXEL};
        rnd1 = {1'b0, maj1} + {1'b0, HALF_PIXEL};
    end

    // slope and first-center correction
    logic signed [SLOPE_W-1:0] slope;
    logic signed [PROD_W-1:0]  prod;
    logic signed [BASE_W-1:0]  base;
    logic signed [ACC_W-1:0]   acc_seed;

    always_comb begin
        logic signed [SLOPE_W-1:0] q_ext;
        q_ext    = $signed({1'b0, o_quo_w});
        slope    = r_dmin_neg ? -q_ext : q_ext;
        prod     = PROD_W'(slope * $signed({1'b0, r_frac}));
        base     = $signed({2'b00, r_min0}) + BASE_W'(r_prod >>> SLOPE_SHIFT);
        // sign-extend the start before widening 8.6 to 10.16
        acc_seed = ACC_W'(base) <<< (SLOPE_SHIFT - FRAC_BITS);
    end

    // pixel selection with tile clamp
    logic signed [ACC_W-SLOPE_SHIFT-1:0] minor;
    logic [PIX_W-1:0]     mn, mj;
    logic [MAJ_PIX_W-1:0] p_next;

    always_comb begin
        minor  = r_acc[ACC_W-1:SLOPE_SHIFT];
        if (minor < 0) begin
            mn = '0;
        end else if (minor > $signed((ACC_W-SLOPE_SHIFT)'(TILE_PIXELS - 1))) begin
            mn = PIX_W'(TILE_PIXELS - 1);
        end else begin
            mn = minor[PIX_W-1:0];
        end
        mj     = (r_p > TILE_MAX) ? TILE_MAX[PIX_W-1:0] : r_p[PIX_W-1:0];
        p_next = r_p + 1'b1;
    end

    hdda_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({r_dmin_mag, SLOPE_SHIFT'(0)}),
        .i_divisor  (r_dmaj),
        .o_quotient (o_quo_w),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0 <= i_x_start;
            r_y0 <= i_y_start;
            r_x1 <= i_x_end;
            r_y1 <= i_y_end;
        end
        if (i_cmd.setup) begin
            r_horiz    <= horiz;
            r_p0       <= rnd0[COORD_W:FRAC_BITS];
            r_p1       <= rnd1[COORD_W:FRAC_BITS];
            r_frac     <= HALF_PIXEL[FRAC_BITS-1:0] - maj0[FRAC_BITS-1:0];
            r_min0     <= min0;
            r_dmaj     <= maj1 - maj0;
            r_dmin_neg <= dmin[COORD_W];
            r_dmin_mag <= dmin[COORD_W] ? COORD_W'(-dmin) : dmin[COORD_W-1:0];
        end
        if (i_cmd.mul) begin
            r_slope <= slope;
            r_prod  <= prod;
        end
        if (i_cmd.init) begin
            r_acc <= acc_seed;
            r_p   <= r_p0;
        end else if (i_cmd.step) begin
            r_acc <= r_acc + ACC_W'(r_slope);
            r_p   <= p_next;
        end
        if (i_cmd.step) begin
            r_px   <= r_horiz ? mj : mn;
            r_py   <= r_horiz ? mn : mj;
            r_last <= (p_next == r_p1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.step;
        end
    end

    assign o_status.zero_len   = (r_p0 == r_p1);
    assign o_status.div_done   = div_done;
    assign o_status.last_pixel = (p_next == r_p1);

    assign o_valid   = r_valid;
    assign o_pixel_x = r_px;
    assign o_pixel_y = r_py;
    assign o_last    = r_last;

    a_run_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_p < r_p1))
        else $error("major counter ran past segment end");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("pixel emitted after final pixel");

endmodule

@@ rtl/core/hdda_ctrl.sv @@
// Controller state machine sequencing setup, division and the pixel run.
module hdda_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    output hdda_pkg::t_dp_cmd     o_cmd,
    input  hdda_pkg::t_dp_status  i_status
);
    import hdda_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start) n_state = ST_SETUP;
            ST_SETUP: n_state = ST_CHECK;
            ST_CHECK: n_state = i_status.zero_len ? ST_IDLE : ST_DIV;
            ST_DIV:   if (i_status.div_done) n_state = ST_MUL;
            ST_MUL:   n_state = ST_INIT;
            ST_INIT:  n_state = ST_RUN;
            ST_RUN:   if (i_status.last_pixel) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_SETUP: o_cmd.setup = 1'b1;
            ST_CHECK: o_cmd.div_start = !i_status.zero_len;
            ST_DIV:   o_cmd = '0;
            ST_MUL:   o_cmd.mul = 1'b1;
            ST_INIT:  o_cmd.init = 1'b1;
            ST_RUN:   o_cmd.step = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

    a_div_idle_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !i_status.div_done)
        else $error("divider finished outside division phase");

endmodule

@@ rtl/core/hairline_dda_rasterizer_core.sv @@
// Hairline DDA rasterizer top level: controller plus datapath.
// The first pixel follows the setup, check, division, multiply and seed states; then one per cycle.
// busy is high from the setup state through the pixel run; a zero-length segment idles after the check.
// The run time is set by the serial slope divider followed by the pixel run.
// Results are strobed for one cycle on o_valid; the receiver cannot stall.
// Reset (i_rst_n low, synchronous) returns the controller to idle and drops o_valid.
module hairline_dda_rasterizer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [hdda_pkg::COORD_W-1:0]  i_x_start,
    input  logic [hdda_pkg::COORD_W-1:0]  i_y_start,
    input  logic [hdda_pkg::COORD_W-1:0]  i_x_end,
    input  logic [hdda_pkg::COORD_W-1:0]  i_y_end,
    output logic                          o_valid,
    output logic [hdda_pkg::PIX_W-1:0]    o_pixel_x,
    output logic [hdda_pkg::PIX_W-1:0]    o_pixel_y,
    output logic                          o_last
);
    import hdda_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    hdda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_cmd    (cmd),
        .i_status (status)
    );

    hdda_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_status  (status),
        .i_x_start (i_x_start),
        .i_y_start (i_y_start),
        .i_x_end   (i_x_end),
        .i_y_end   (i_y_end),
        .o_valid   (o_valid),
        .o_pixel_x (o_pixel_x),
        .o_pixel_y (o_pixel_y),
        .o_last    (o_last)
    );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the hairline DDA rasterizer core.
`timescale 1ns / 1ps

module testbench;
    import hdda_pkg::*;

    localparam longint HALF_PX   = longint'(HALF_PIXEL);
    localparam longint FRAC_MASK = (1 << FRAC_BITS) - 1;
    localparam longint COORD_MAX = (1 << COORD_W) - 1;
    localparam longint TILE_LAST = TILE_PIXELS - 1;

    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic             last;
    } t_pixel;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [COORD_W-1:0] i_x_start;
    logic [COORD_W-1:0] i_y_start;
    logic [COORD_W-1:0] i_x_end;
    logic [COORD_W-1:0] i_y_end;
    logic               o_valid;
    logic [PIX_W-1:0]   o_pixel_x;
    logic [PIX_W-1:0]   o_pixel_y;
    logic               o_last;

    t_pixel expected_pixels[$];
    int     mismatch_count = 0;
    bit     sender_idles   = 1'b1;

    hairline_dda_rasterizer_core u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_x_start (i_x_start),
        .i_y_start (i_y_start),
        .i_x_end   (i_x_end),
        .i_y_end   (i_y_end),
        .o_valid   (o_valid),
        .o_pixel_x (o_pixel_x),
        .o_pixel_y (o_pixel_y),
        .o_last    (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [PIX_W-1:0] clamp_to_tile(input longint v);
        if (v < 0) return '0;
        if (v > TILE_LAST) return PIX_W'(TILE_LAST);
        return PIX_W'(v);
    endfunction

    function automatic logic [COORD_W-1:0] clip_coord(input longint v);
        if (v < 0) return '0;
        if (v > COORD_MAX) return COORD_W'(COORD_MAX);
        return COORD_W'(v);
    endfunction

    // Coordinates at the tile border or at or beside a pixel rounding boundary.
    function automatic longint pick_edge_coord();
        longint base;
        base = longint'($urandom_range(0, TILE_LAST)) << FRAC_BITS;
        case ($urandom_range(0, 4))
            0: return 0;
            1: return COORD_MAX;
            2: return base + HALF_PX + 1;
            3: return base + HALF_PX - 1;
            default: return base + HALF_PX;
        endcase
    endfunction

    // Walk the segment in major-axis order and queue one pixel per step.
    task automatic rasterize_segment(input logic [COORD_W-1:0] xs, ys, xe, ye);
        longint x0, y0, x1, y1, adx, ady, maj0, maj1, min0, min1, t;
        longint p0, p1, slope, acc;
        bit     horiz;
        t_pixel px;
        x0 = xs;
        y0 = ys;
        x1 = xe;
        y1 = ye;
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;
        horiz = adx > ady;
        if (horiz) begin
            maj0 = x0; maj1 = x1; min0 = y0; min1 = y1;
        end else begin
            maj0 = y0; maj1 = y1; min0 = x0; min1 = x1;
        end
        if (maj0 > maj1) begin
            t = maj0; maj0 = maj1; maj1 = t;
            t = min0; min0 = min1; min1 = t;
        end
        p0 = (maj0 + HALF_PX) >>> FRAC_BITS;
        p1 = (maj1 + HALF_PX) >>> FRAC_BITS;
        if (p0 == p1) return;
        slope = ((min1 - min0) * (longint'(1) << SLOPE_SHIFT)) / (maj1 - maj0);
        // advance to the first pixel center, then widen 8.6 to 10.16
        acc = min0 + ((slope * ((HALF_PX - maj0) & FRAC_MASK)) >>> SLOPE_SHIFT);
        acc = acc << (SLOPE_SHIFT - FRAC_BITS);
        for (longint p = p0; p < p1; p++) begin
            if (horiz) begin
                px.x = clamp_to_tile(p);
                px.y = clamp_to_tile(acc >>> SLOPE_SHIFT);
            end else begin
                px.x = clamp_to_tile(acc >>> SLOPE_SHIFT);
                px.y = clamp_to_tile(p);
            end
            px.last = (p + 1 == p1);
            expected_pixels.push_back(px);
            acc += slope;
        end
    endtask

    task automatic send_segment(input logic [COORD_W-1:0] xs, ys, xe, ye);
        int gap;
        gap = sender_idles ? $urandom_range(0, 19) : 0;
        @(posedge i_clk);
        repeat (gap) @(posedge i_clk);
        start     <= 1'b1;
        i_x_start <= xs;
        i_y_start <= ys;
        i_x_end   <= xe;
        i_y_end   <= ye;
        do @(posedge i_clk); while (busy !== 1'b0);
        rasterize_segment(xs, ys, xe, ye);
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_pixels
        t_pixel want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel x=%0d y=%0d last=%0b",
                         $time, o_pixel_x, o_pixel_y, o_last);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_x !== want.x) begin
                    $display("%0t: pixel_x expected %0d got %0d", $time, want.x, o_pixel_x);
                    mismatch_count++;
                end
                if (o_pixel_y !== want.y) begin
                    $display("%0t: pixel_y expected %0d got %0d", $time, want.y, o_pixel_y);
                    mismatch_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %0b got %0b", $time, want.last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_full_span();
        send_segment(12'd0, 12'd0, 12'd4095, 12'd4095);
        send_segment(12'd4095, 12'd0, 12'd0, 12'd4095);
        send_segment(12'd0, 12'd0, 12'd4095, 12'd0);
        send_segment(12'd0, 12'd4095, 12'd0, 12'd0);
        send_segment(12'd4095, 12'd4095, 12'd0, 12'd4095);
        send_segment(12'd4095, 12'd4095, 12'd0, 12'd0);
        wait_drained();
    endtask

    // Both ends land on one major pixel: nothing comes out.
    task automatic test_zero_length();
        send_segment(12'd100, 12'd100, 12'd100, 12'd100);
        send_segment(12'd0, 12'd0, 12'd31, 12'd31);
        send_segment(12'd33, 12'd0, 12'd95, 12'd10);
        send_segment(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        wait_drained();
    endtask

    task automatic test_short_and_ties();
        send_segment(12'd0, 12'd0, 12'd32, 12'd0);
        send_segment(12'd31, 12'd500, 12'd32, 12'd500);
        send_segment(12'd0, 12'd0, 12'd640, 12'd640);
        send_segment(12'd640, 12'd0, 12'd0, 12'd640);
        send_segment(12'd200, 12'd1000, 12'd1900, 12'd300);
        send_segment(12'd1000, 12'd3000, 12'd1200, 12'd100);
        wait_drained();
    endtask

    // Minor values near the tile border, mostly with the largest first-center step.
    task automatic test_tile_edges();
        send_segment(12'd33, 12'd5, 12'd96, 12'd0);
        send_segment(12'd33, 12'd4080, 12'd96, 12'd4095);
        send_segment(12'd5, 12'd33, 12'd0, 12'd96);
        send_segment(12'd4090, 12'd33, 12'd4095, 12'd4000);
        send_segment(12'd4095, 12'd4063, 12'd4032, 12'd4095);
        wait_drained();
    endtask

    task automatic test_random_segments(input int count);
        longint xs, ys, xe, ye, d;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) sender_idles = ($urandom_range(0, 2) != 0);
            if (i % 150 == 149) wait_drained();
            xs = $urandom_range(0, COORD_MAX);
            ys = $urandom_range(0, COORD_MAX);
            xe = $urandom_range(0, COORD_MAX);
            ye = $urandom_range(0, COORD_MAX);
            case ($urandom_range(0, 9))
                3, 4: begin
                    xe = xs + longint'($urandom_range(0, 400)) - 200;
                    ye = ys + longint'($urandom_range(0, 400)) - 200;
                end
                5: begin
                    if ($urandom_range(0, 1)) xe = xs;
                    else ye = ys;
                end
                6: begin
                    d  = $urandom_range(0, 1500);
                    xe = xs + ($urandom_range(0, 1) ? d : -d);
                    ye = ys + ($urandom_range(0, 1) ? d : -d);
                end
                7: begin
                    xe = xs + longint'($urandom_range(0, 40)) - 20;
                    ye = ys + longint'($urandom_range(0, 40)) - 20;
                end
                8: begin
                    xs = pick_edge_coord();
                    ys = pick_edge_coord();
                    xe = pick_edge_coord();
                    ye = pick_edge_coord();
                end
                default: ;
            endcase
            send_segment(clip_coord(xs), clip_coord(ys), clip_coord(xe), clip_coord(ye));
        end
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_x_start <= '0;
        i_y_start <= '0;
        i_x_end   <= '0;
        i_y_end   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_full_span();
        test_zero_length();
        test_short_and_ties();
        test_tile_edges();
        test_random_segments(450);

        wait_drained();
        repeat (120) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
